// File: hdl/char_buffer_insert_erase_core_assert.svh
// assertion macros for the character buffer core
`ifndef CHAR_BUFFER_INSERT_ERASE_CORE_ASSERT_SVH
`define CHAR_BUFFER_INSERT_ERASE_CORE_ASSERT_SVH

// same-cycle implication
`define CBIE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cbie assertion failed");

// next-cycle implication
`define CBIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbie assertion failed");

`endif

// File: hdl/cbie_pkg.sv
// types and constants shared by the character buffer modules
package cbie_pkg;

	localparam int LEN_W = 7;

	localparam logic [2:0] FN_INSERT     = 3'd0;
	localparam logic [2:0] FN_ERASE      = 3'd1;
	localparam logic [2:0] FN_PUSH_FRONT = 3'd2;
	localparam logic [2:0] FN_POP_FRONT  = 3'd3;
	localparam logic [2:0] FN_PUSH_BACK  = 3'd4;
	localparam logic [2:0] FN_POP_BACK   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_INDEX = 2'd3;

	localparam logic [1:0] MODE_HOLD = 2'd0;
	localparam logic [1:0] MODE_UP   = 2'd1;
	localparam logic [1:0] MODE_DOWN = 2'd2;

	localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

	typedef struct packed {
		logic [2:0]       func;
		logic [LEN_W-1:0] position;
		logic [7:0]       byte_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       byte_out;
		logic [LEN_W-1:0] new_length;
		logic [1:0]       status;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [LEN_W-1:0] at;
		logic [7:0]       byte_in;
	} cell_ctl_t;

endpackage

// File: hdl/cbie_cell.sv
// one byte slot of the buffer, shifts up or down with its neighbors
module cbie_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cbie_pkg::cell_ctl_t ctl,
	input  logic [7:0]         left_byte,
	input  logic [7:0]         right_byte,
	output logic [7:0]         q,
	output logic [7:0]         tap
);

	logic [7:0] data_q;
	logic       above;
	logic       here;

	assign above = IDX > int'(ctl.at);
	assign here  = IDX == int'(ctl.at);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= 8'd0;
		end else begin
			case (ctl.mode)
				cbie_pkg::MODE_UP: begin
					if (above) begin
						data_q <= left_byte;
					end else if (here) begin
						data_q <= ctl.byte_in;
					end
				end
				cbie_pkg::MODE_DOWN: begin
					if (above || here) begin
						data_q <= right_byte;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign q   = data_q;
	assign tap = here ? data_q : 8'd0;

endmodule

// File: hdl/char_buffer_insert_erase_core.sv
// top level: control, length and capacity registers, row of byte cells
// an accepted item's result appears on the output register in the cycle after it is accepted
// throughput: one item per cycle while out_ready is high; the cells at and above the target
// position shift or load in the same cycle, so the cell row update sets the rate
// reset clears every cell to zero, the length to zero and the capacity register to 64
`include "char_buffer_insert_erase_core_assert.svh"
module char_buffer_insert_erase_core #(
	parameter int CAPACITY = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cbie_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cbie_pkg::out_item_t           out_data,
	input  logic                          cfg_wr_en,
	input  logic [cbie_pkg::LEN_W-1:0]    cfg_wr_data
);

	localparam int NCELL = (CAPACITY > 127) ? 127 : CAPACITY;
	localparam logic [cbie_pkg::LEN_W-1:0] CAP_L = cbie_pkg::LEN_W'(NCELL);

	logic [cbie_pkg::LEN_W-1:0] cap_q;
	logic [cbie_pkg::LEN_W-1:0] len_q;
	logic [cbie_pkg::LEN_W-1:0] eff_cap;
	logic [cbie_pkg::LEN_W-1:0] len_next;
	logic                       out_valid_q;
	cbie_pkg::out_item_t        out_q;
	logic                       in_fire;
	logic                       full;
	logic                       empty;
	logic [1:0]                 st;
	logic [1:0]                 op_mode;
	logic [cbie_pkg::LEN_W-1:0] op_at;
	logic                       is_pop;
	logic [7:0]                 sel_byte;
	cbie_pkg::cell_ctl_t        ctl;
	logic [7:0]                 cell_q   [NCELL];
	logic [7:0]                 cell_tap [NCELL];

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = cbie_pkg::LEN_W'(1);
		end else if (int'(cap_q) > NCELL) begin
			eff_cap = CAP_L;
		end else begin
			eff_cap = cap_q;
		end
	end

	assign full  = len_q >= eff_cap;
	assign empty = len_q == '0;

	always_comb begin
		st      = cbie_pkg::ST_OK;
		op_mode = cbie_pkg::MODE_HOLD;
		op_at   = '0;
		is_pop  = 1'b0;
		case (in_data.func)
			cbie_pkg::FN_INSERT: begin
				if (full) begin
					st = cbie_pkg::ST_FULL;
				end else if (in_data.position > len_q) begin
					st = cbie_pkg::ST_INDEX;
				end else begin
					op_mode = cbie_pkg::MODE_UP;
					op_at   = in_data.position;
				end
			end
			cbie_pkg::FN_ERASE: begin
				if (empty) begin
					st = cbie_pkg::ST_EMPTY;
				end else if (in_data.position >= len_q) begin
					st = cbie_pkg::ST_INDEX;
				end else begin
					op_mode = cbie_pkg::MODE_DOWN;
					op_at   = in_data.position;
				end
			end
			cbie_pkg::FN_PUSH_FRONT: begin
				if (full) begin
					st = cbie_pkg::ST_FULL;
				end else begin
					op_mode = cbie_pkg::MODE_UP;
				end
			end
			cbie_pkg::FN_POP_FRONT: begin
				if (empty) begin
					st = cbie_pkg::ST_EMPTY;
				end else begin
					op_mode = cbie_pkg::MODE_DOWN;
					is_pop  = 1'b1;
				end
			end
			cbie_pkg::FN_PUSH_BACK: begin
				if (full) begin
					st = cbie_pkg::ST_FULL;
				end else begin
					op_mode = cbie_pkg::MODE_UP;
					op_at   = len_q;
				end
			end
			cbie_pkg::FN_POP_BACK: begin
				if (empty) begin
					st = cbie_pkg::ST_EMPTY;
				end else begin
					op_mode = cbie_pkg::MODE_DOWN;
					op_at   = len_q - 1'b1;
					is_pop  = 1'b1;
				end
			end
			default: begin
				st = cbie_pkg::ST_INDEX;
			end
		endcase
	end

	always_comb begin
		case (op_mode)
			cbie_pkg::MODE_UP:   len_next = len_q + 1'b1;
			cbie_pkg::MODE_DOWN: len_next = len_q - 1'b1;
			default:             len_next = len_q;
		endcase
	end

	assign ctl.mode    = in_fire ? op_mode : cbie_pkg::MODE_HOLD;
	assign ctl.at      = op_at;
	assign ctl.byte_in = in_data.byte_in;

	// row of cells, each takes its neighbor's byte on a shift
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic [7:0] left_b;
		logic [7:0] right_b;
		if (i == 0) begin : g_first
			assign left_b = 8'd0;
		end else begin : g_mid_l
			assign left_b = cell_q[i-1];
		end
		if (i == NCELL - 1) begin : g_last
			assign right_b = 8'd0;
		end else begin : g_mid_r
			assign right_b = cell_q[i+1];
		end
		cbie_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.left_byte  (left_b),
			.right_byte (right_b),
			.q          (cell_q[i]),
			.tap        (cell_tap[i])
		);
	end

	always_comb begin
		sel_byte = 8'd0;
		for (int i = 0; i < NCELL; i++) begin
			sel_byte = sel_byte | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= cbie_pkg::CAP_RESET;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (in_fire) begin
				len_q       <= len_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q.byte_out   <= is_pop ? sel_byte : 8'd0;
			out_q.new_length <= len_next;
			out_q.status     <= st;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`CBIE_ASSERT_NOW(a_len_bound, clk, arst_n, 1'b1, len_q <= CAP_L)
	`CBIE_ASSERT_NEXT(a_fail_keeps_len, clk, arst_n, in_fire && st != cbie_pkg::ST_OK, len_q == $past(len_q))
	`CBIE_ASSERT_NEXT(a_grow_len, clk, arst_n, in_fire && op_mode == cbie_pkg::MODE_UP, len_q == $past(len_q) + 1'b1)
	`CBIE_ASSERT_NOW(a_byte_only_ok, clk, arst_n, out_valid_q && out_q.byte_out != 8'd0, out_q.status == cbie_pkg::ST_OK)

endmodule
